// ----- hw/rtl/dblg_pkg.sv -----
// Shared constants, register map and exponent table function for the dB to gain block.
package dblg_pkg;

  // Field widths
  localparam int unsigned LevelW = 32;
  localparam int unsigned GainW  = 31;
  localparam int unsigned CfgLevelW = 16;
  localparam int unsigned CoefW  = 40;
  localparam int unsigned MantW  = 31;  // Q2.29 mantissa, up to 2^30
  localparam int unsigned ExpIntW = 8;  // signed integer part of the exponent

  // Configuration port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] REG_LEVEL_CEILING  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MUTE_LEVEL     = 2'd1;
  localparam logic [RegIdxW-1:0] REG_LOG_SCALE_COEF = 2'd2;

  localparam logic signed [CfgLevelW-1:0] LevelCeilingRst = 16'sd6144;
  localparam logic signed [CfgLevelW-1:0] MuteLevelRst    = -16'sd30720;
  localparam logic [CoefW-1:0]            LogScaleCoefRst = 40'd182624928350;

  localparam logic [GainW-1:0] GainMax = 31'h7FFF_FFFF;
  localparam logic [63:0]      Ln2Q62  = 64'h2C5C_85FD_F473_DE6B;

  // Table entry round(2^(idx/2^index_bits) * 2^29), from a Taylor series at Q62
  function automatic logic [MantW-1:0] exp2_entry(input int unsigned idx,
                                                  input int unsigned index_bits);
    logic [63:0]  y;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] prod;
    logic [63:0]  rnd;
    y    = (Ln2Q62 >> index_bits) * 64'(idx);
    term = 64'h4000_0000_0000_0000;
    sum  = term;
    for (int k = 1; k <= 30; k++) begin
      prod = 128'(term) * 128'(y);
      term = 64'(prod >> 62) / 64'(k);
      sum  = sum + term;
    end
    rnd = (sum + 64'h1_0000_0000) >> 33;
    return rnd[MantW-1:0];
  endfunction

endpackage

// ----- hw/rtl/dblg_level_if.sv -----
// Stream channel that carries one dB level item.
interface dblg_level_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dblg_pkg::LevelW-1:0]     level_db;

  modport source (output valid, output level_db, input ready);
  modport sink   (input valid, input level_db, output ready);
endinterface

// ----- hw/rtl/dblg_gain_if.sv -----
// Stream channel that carries one linear gain item.
interface dblg_gain_if;
  logic                           valid;
  logic                           ready;
  logic [dblg_pkg::GainW-1:0]     linear_gain;

  modport source (output valid, output linear_gain, input ready);
  modport sink   (input valid, input linear_gain, output ready);
endinterface

// ----- hw/rtl/db_to_linear_gain.sv -----
// Top level: pipelined dB level to linear gain converter with APB register port.
//
//   channel   direction  handshake        payload
//   level_i   in         valid / ready    level_db     signed Q23.8, 32 bits
//   gain_o    out        valid / ready    linear_gain  unsigned Q4.27, 31 bits
//   apb       in         psel / penable   level_ceiling, mute_level, log_scale_coef
//
// One item per cycle while gain_o is ready; each item passes six register stages (clamp, exponent
// multiply, table read, interpolation multiply, rounding add, shift) before it shows on gain_o.
// Every stage holds only while the stage after it is full and stalled, so empty stages are
// filled under a stall. Reset clears all valid bits and loads the register defaults; the
// exponent table is constant logic and needs no fill.
module db_to_linear_gain #(
  parameter int unsigned TABLE_INDEX_BITS = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  dblg_level_if.sink                           level_i,
  dblg_gain_if.source                          gain_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dblg_pkg::ApbAddrW-1:0]        paddr,
  input  logic [dblg_pkg::ApbDataW-1:0]        pwdata,
  output logic [dblg_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  localparam int unsigned FracBits = 32 - TABLE_INDEX_BITS;
  localparam int unsigned TabLen   = 2 ** TABLE_INDEX_BITS + 1;
  localparam int unsigned AddrW    = TABLE_INDEX_BITS + 1;
  localparam int unsigned ProdW    = dblg_pkg::MantW + FracBits;
  localparam logic [ProdW:0] RoundHalf = (ProdW + 1)'(1) << (FracBits - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [dblg_pkg::CfgLevelW-1:0] level_ceiling_q, mute_level_q;
  logic [dblg_pkg::CoefW-1:0]            log_scale_coef_q;
  logic [dblg_pkg::RegIdxW-1:0]          reg_idx;
  logic                                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dblg_pkg::ApbAddrW-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_ceiling_q  <= dblg_pkg::LevelCeilingRst;
      mute_level_q     <= dblg_pkg::MuteLevelRst;
      log_scale_coef_q <= dblg_pkg::LogScaleCoefRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dblg_pkg::REG_LEVEL_CEILING:  level_ceiling_q  <= pwdata[dblg_pkg::CfgLevelW-1:0];
        dblg_pkg::REG_MUTE_LEVEL:     mute_level_q     <= pwdata[dblg_pkg::CfgLevelW-1:0];
        dblg_pkg::REG_LOG_SCALE_COEF: log_scale_coef_q <= pwdata[dblg_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      dblg_pkg::REG_LEVEL_CEILING:  prdata = dblg_pkg::ApbDataW'(level_ceiling_q);
      dblg_pkg::REG_MUTE_LEVEL:     prdata = dblg_pkg::ApbDataW'(mute_level_q);
      dblg_pkg::REG_LOG_SCALE_COEF: prdata = dblg_pkg::ApbDataW'(log_scale_coef_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Exponent table, 2^(i/2^TABLE_INDEX_BITS) in Q2.29
  logic [dblg_pkg::MantW-1:0] exp2_rom [TabLen];

  for (genvar gi = 0; gi < TabLen; gi++) begin : g_rom
    localparam logic [dblg_pkg::MantW-1:0] Entry =
      dblg_pkg::exp2_entry(gi, TABLE_INDEX_BITS);
    assign exp2_rom[gi] = Entry;
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || gain_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign level_i.ready = en1;
  assign gain_o.valid  = v6_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= level_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp to the ceiling and detect mute
  logic signed [dblg_pkg::LevelW-1:0]    ceil_ext, mute_ext, clamped;
  logic                                  s1_mute_d, s1_mute_q;
  logic signed [dblg_pkg::CfgLevelW-1:0] s1_level_q;

  assign ceil_ext  = dblg_pkg::LevelW'(level_ceiling_q);
  assign mute_ext  = dblg_pkg::LevelW'(mute_level_q);
  assign clamped   = (level_i.level_db > ceil_ext) ? ceil_ext : level_i.level_db;
  assign s1_mute_d = (clamped <= mute_ext);

  // A level above the mute level is within 16 bits
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mute_q  <= s1_mute_d;
      s1_level_q <= clamped[dblg_pkg::CfgLevelW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: exponent product level * coef, Q8 * Q40 = Q48
  logic signed [55:0] s2_prod_d, s2_prod_q;
  logic               s2_mute_q;

  assign s2_prod_d = s1_level_q * $signed({1'b0, log_scale_coef_q});

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_mute_q <= s1_mute_q;
      s2_prod_q <= s2_prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: split the Q32 exponent and read the two table neighbors
  logic [31:0]                             frac;
  logic [AddrW-1:0]                        rom_addr, rom_addr_nx;
  logic [dblg_pkg::MantW-1:0]              rom_lo, rom_hi;
  logic                                    s3_mute_q;
  logic signed [dblg_pkg::ExpIntW-1:0]     s3_n_q;
  logic [dblg_pkg::MantW-1:0]              s3_base_q, s3_diff_q;
  logic [FracBits-1:0]                     s3_lam_q;

  // Dropping the low 16 bits of the product is a floor shift
  assign frac        = s2_prod_q[47:16];
  assign rom_addr    = {1'b0, frac[31:FracBits]};
  assign rom_addr_nx = rom_addr + AddrW'(1);
  assign rom_lo      = exp2_rom[rom_addr];
  assign rom_hi      = exp2_rom[rom_addr_nx];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_mute_q <= s2_mute_q;
      s3_n_q    <= s2_prod_q[55:48];
      s3_base_q <= rom_lo;
      s3_diff_q <= rom_hi - rom_lo;
      s3_lam_q  <= frac[FracBits-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: interpolation product
  logic                                s4_mute_q;
  logic signed [dblg_pkg::ExpIntW-1:0] s4_n_q;
  logic [dblg_pkg::MantW-1:0]          s4_base_q;
  logic [ProdW-1:0]                    s4_prod_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_mute_q <= s3_mute_q;
      s4_n_q    <= s3_n_q;
      s4_base_q <= s3_base_q;
      s4_prod_q <= ProdW'(s3_diff_q) * ProdW'(s3_lam_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: round the interpolation step and add the base
  logic [ProdW:0]                      interp_rnd;
  logic [dblg_pkg::MantW-1:0]          interp;
  logic                                s5_mute_q;
  logic signed [dblg_pkg::ExpIntW-1:0] s5_n_q;
  logic [dblg_pkg::MantW-1:0]          s5_mant_q;

  assign interp_rnd = {1'b0, s4_prod_q} + RoundHalf;
  assign interp     = dblg_pkg::MantW'(interp_rnd >> FracBits);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_mute_q <= s4_mute_q;
      s5_n_q    <= s4_n_q;
      s5_mant_q <= s4_base_q + interp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: scale by 2^(n-2) with rounding and saturation
  logic [7:0]                    rshift;
  logic [39:0]                   rsum;
  logic [dblg_pkg::GainW-1:0]    gain_d, gain_q;

  assign rshift = 8'd2 - 8'(s5_n_q);
  assign rsum   = 40'(s5_mant_q) + (40'(1) << (rshift - 8'd1));

  always_comb begin
    if (s5_mute_q) begin
      gain_d = '0;
    end else if (s5_n_q >= 8'sd4) begin
      gain_d = dblg_pkg::GainMax;
    end else if (s5_n_q == 8'sd3) begin
      // Double; only a mantissa of exactly 2.0 overflows
      gain_d = s5_mant_q[30] ? dblg_pkg::GainMax : {s5_mant_q[29:0], 1'b0};
    end else if (s5_n_q == 8'sd2) begin
      gain_d = s5_mant_q;
    end else if (rshift >= 8'd40) begin
      gain_d = '0;
    end else begin
      gain_d = dblg_pkg::GainW'(rsum >> rshift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o.linear_gain = gain_q;

endmodule

// ----- sim/db_to_linear_gain_test.sv -----
// Self-checking testbench for the dB level to linear gain converter.
module db_to_linear_gain_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dblg_pkg::*;

  localparam int unsigned TBL_BITS       = 7;
  localparam int unsigned TBL_LEN        = (1 << TBL_BITS) + 1;
  localparam int unsigned FRAC_SHIFT     = 32 - TBL_BITS;
  localparam int unsigned PIPE_DEPTH     = 6;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_CHUNK   = 145;
  localparam logic [63:0] LN2_Q62        = 64'h2C5C_85FD_F473_DE6B;
  localparam longint unsigned GAIN_LIMIT = 64'h7FFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dblg_level_if lvl_if ();
  dblg_gain_if  gain_if ();

  db_to_linear_gain #(
    .TABLE_INDEX_BITS(TBL_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .level_i(lvl_if),
    .gain_o (gain_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk_i = ~clk_i;

  // Register contents as the block should see them
  logic signed [CfgLevelW-1:0] ceil_cfg = LevelCeilingRst;
  logic signed [CfgLevelW-1:0] mute_cfg = MuteLevelRst;
  logic [CoefW-1:0]            coef_cfg = LogScaleCoefRst;

  longint unsigned    pow2_table [TBL_LEN];
  logic [GainW-1:0]   gain_queue [$];
  int unsigned        fail_count = 0;
  int unsigned        src_idle_pct = 24;
  int unsigned        snk_idle_pct = 76;
  int unsigned        hold_req = 0;
  int unsigned        hold_left = 0;
  int unsigned        quiet_cycles = 0;

  // Fill 2^(i/128) in Q2.29 from an exp series evaluated at Q62
  initial begin : build_pow2_table
    logic [63:0]  exp_arg;
    logic [63:0]  term;
    logic [63:0]  total;
    logic [127:0] wide;
    for (int i = 0; i < TBL_LEN; i++) begin
      exp_arg = (LN2_Q62 >> TBL_BITS) * 64'(i);
      term    = 64'd1 << 62;
      total   = term;
      for (int k = 1; k <= 30; k++) begin
        wide  = 128'(term) * 128'(exp_arg);
        term  = wide[125:62] / 64'(k);
        total = total + term;
      end
      pow2_table[i] = (total + (64'd1 << 32)) >> 33;
    end
  end

  // Expected gain for one level under the current register contents
  function automatic logic [GainW-1:0] predict_gain(input logic [LevelW-1:0] lvl);
    longint          db;
    longint          u;
    longint          n;
    longint          sh;
    longint unsigned frac;
    longint unsigned idx;
    longint unsigned lam;
    longint unsigned d;
    longint unsigned v;
    longint unsigned g;
    db = longint'(signed'(lvl));
    if (db > longint'(ceil_cfg)) db = longint'(ceil_cfg);
    if (db <= longint'(mute_cfg)) return '0;
    // Exponent in Q32, floored; split into integer part and fraction
    u    = (db * longint'(coef_cfg)) >>> 16;
    n    = u >>> 32;
    frac = u[31:0];
    idx  = frac >> FRAC_SHIFT;
    lam  = frac & ((64'd1 << FRAC_SHIFT) - 1);
    // Interpolate between table neighbors with rounding
    d = pow2_table[idx + 1] - pow2_table[idx];
    v = pow2_table[idx] + ((d * lam + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
    // Move Q2.29 to Q4.27 by n-2, round on right shifts, saturate
    sh = n - 2;
    if (sh >= 2) begin
      g = GAIN_LIMIT;
    end else if (sh >= 0) begin
      g = v << sh;
    end else if (sh <= -40) begin
      g = 0;
    end else begin
      g = (v + (64'd1 << (-sh - 1))) >> (-sh);
    end
    if (g > GAIN_LIMIT) g = GAIN_LIMIT;
    return g[GainW-1:0];
  endfunction

  // Random level: mostly within the 16-bit range, some near the thresholds, some wide
  function automatic logic [LevelW-1:0] pick_level();
    logic signed [15:0] near;
    int unsigned        sel;
    sel  = $urandom_range(99);
    near = 16'($urandom());
    if (sel < 15) return $urandom();
    if (sel < 40) begin
      return LevelW'(($urandom_range(1) ? int'(ceil_cfg) : int'(mute_cfg)) +
                     int'($urandom_range(8)) - 4);
    end
    return {{16{near[15]}}, near};
  endfunction

  // Offer one item after a random gap; record its expected gain when accepted
  task automatic send_level(input logic [LevelW-1:0] lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      lvl_if.valid    <= 1'b0;
      lvl_if.level_db <= $urandom();
      @(negedge clk_i);
    end
    lvl_if.valid    <= 1'b1;
    lvl_if.level_db <= lvl;
    @(posedge clk_i);
    while (!lvl_if.ready) @(posedge clk_i);
    gain_queue.push_back(predict_gain(lvl));
    @(negedge clk_i);
  endtask

  // Stop offering items and wait until every expected gain has come out
  task automatic wait_drained();
    lvl_if.valid <= 1'b0;
    while (gain_queue.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(negedge clk_i);
  endtask

  task automatic set_idle(input int unsigned src_pct, input int unsigned snk_pct);
    lvl_if.valid <= 1'b0;
    @(posedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    @(negedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] mask;
    string               rname;
    mask = (64'd1 << CfgLevelW) - 1;
    case (idx)
      REG_LEVEL_CEILING: rname = "level_ceiling";
      REG_MUTE_LEVEL:    rname = "mute_level";
      default: begin
        rname = "log_scale_coef";
        mask  = (64'd1 << CoefW) - 1;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_LEVEL_CEILING: ceil_cfg = value[CfgLevelW-1:0];
      REG_MUTE_LEVEL:    mute_cfg = value[CfgLevelW-1:0];
      default:           coef_cfg = value[CoefW-1:0];
    endcase
    // Back-to-back read of the same register
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) !== (value & mask)) begin
      $error("%s readback: expected 0x%0h, actual 0x%0h", rname, value & mask, prdata & mask);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic signed [CfgLevelW-1:0] ceil_v,
                                input logic signed [CfgLevelW-1:0] mute_v,
                                input logic [CoefW-1:0]            coef_v);
    wait_drained();
    write_reg(REG_LEVEL_CEILING, 64'(ceil_v));
    write_reg(REG_MUTE_LEVEL, 64'(mute_v));
    write_reg(REG_LOG_SCALE_COEF, 64'(coef_v));
  endtask

  // Random register contents, extremes included; mute usually below the ceiling
  task automatic pick_settings();
    logic signed [CfgLevelW-1:0] ceil_v;
    logic signed [CfgLevelW-1:0] mute_v;
    logic signed [CfgLevelW-1:0] tmp;
    logic [CoefW-1:0]            coef_v;
    ceil_v = ($urandom_range(5) == 0) ? 16'sh7FFF : 16'($urandom());
    mute_v = ($urandom_range(5) == 0) ? 16'sh8000 : 16'($urandom());
    if ($urandom_range(3) != 0 && mute_v > ceil_v) begin
      tmp    = mute_v;
      mute_v = ceil_v;
      ceil_v = tmp;
    end
    case ($urandom_range(4))
      0:       coef_v = LogScaleCoefRst;
      1:       coef_v = {8'($urandom()), $urandom()};
      2:       coef_v = LogScaleCoefRst + 40'($urandom()) - 40'($urandom());
      3:       coef_v = '1;
      default: coef_v = 40'($urandom());
    endcase
    apply_settings(ceil_v, mute_v, coef_v);
  endtask

  // Field extremes and both thresholds under the reset settings
  task automatic test_default_levels();
    logic [LevelW-1:0] levels [$];
    set_idle(24, 76);
    levels = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd6144, 32'd6145,
               -32'sd30720, -32'sd30719, 32'd256, -32'sd2560, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (levels[i]) send_level(levels[i]);
  endtask

  // Saturation, tiny gains, right shifts of 40 and more, zero coefficient, mute over ceiling
  task automatic test_register_extremes();
    apply_settings(16'sh7FFF, 16'sh8000, LogScaleCoefRst);
    send_level(32'd32767);
    send_level(-32'sd32767);
    send_level(-32'sd32768);
    apply_settings(16'sh7FFF, 16'sh8000, '1);
    send_level(32'd32767);
    send_level(-32'sd32767);
    send_level(32'hFFFF_FFFF);
    send_level(32'd1);
    apply_settings(16'sh7FFF, 16'sh8000, '0);
    send_level(32'd12345);
    apply_settings(16'sd100, 16'sd100, LogScaleCoefRst);
    send_level(32'h7FFF_FFFF);
    send_level(32'd0);
    apply_settings(16'sh8000, 16'sh7FFF, LogScaleCoefRst);
    send_level(32'd1);
  endtask

  // Hold the output off long enough to back the pipeline up, then pause the input
  task automatic test_output_stall();
    apply_settings(LevelCeilingRst, MuteLevelRst, LogScaleCoefRst);
    set_idle(0, 0);
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (40) send_level(pick_level());
    wait_drained();
    repeat (30) send_level(pick_level());
    wait_drained();
  endtask

  // Random levels over three idle patterns, new settings every chunk
  task automatic test_random_levels();
    int unsigned idle_plan [3][2] = '{'{24, 76}, '{76, 24}, '{0, 0}};
    for (int p = 0; p < 3; p++) begin
      set_idle(idle_plan[p][0], idle_plan[p][1]);
      repeat (4) begin
        pick_settings();
        repeat (RANDOM_CHUNK) send_level(pick_level());
      end
    end
  endtask

  // Drive the output ready: random idling, or a counted hold-off on request
  always @(negedge clk_i) begin : drive_gain_ready
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      gain_if.ready <= 1'b0;
      hold_left--;
    end else begin
      gain_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare each gain item with the oldest expectation
  always @(posedge clk_i) begin : check_gain
    logic [GainW-1:0] want;
    if (rst_ni && gain_if.valid && gain_if.ready) begin
      if (gain_queue.size() == 0) begin
        $error("linear_gain: unexpected item, actual %0d", gain_if.linear_gain);
        fail_count++;
      end else begin
        want = gain_queue.pop_front();
        if (gain_if.linear_gain !== want) begin
          $error("linear_gain: expected %0d, actual %0d", want, gain_if.linear_gain);
          fail_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (lvl_if.valid && lvl_if.ready) || (gain_if.valid && gain_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[db_to_linear_gain] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    lvl_if.valid    = 1'b0;
    lvl_if.level_db = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_levels();
    test_register_extremes();
    test_output_stall();
    test_random_levels();

    wait_drained();
    repeat (PIPE_DEPTH * 4) @(posedge clk_i);
    if (fail_count == 0 && gain_queue.size() == 0) begin
      $display("[db_to_linear_gain] OK");
    end else begin
      $display("[db_to_linear_gain] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dblg_pkg.sv
hw/rtl/dblg_level_if.sv
hw/rtl/dblg_gain_if.sv
hw/rtl/db_to_linear_gain.sv
sim/db_to_linear_gain_test.sv
